// ----- design/hcbp_pkg.sv -----
// Shared types and constants for the Huffman code bit packer.
// No dependencies; imported by every module of the block.
package hcbp_pkg;

    // Field widths of the request and result items
    localparam int CMD_W      = 2;
    localparam int SYM_W      = 7;
    localparam int CODE_W     = 16;
    localparam int CLEN_W     = 5;

    // Packing geometry
    localparam int MAX_CODE_LEN = 16;
    localparam int GROUP_BITS   = 7;
    localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1);
    // Leftover bits (below one group) plus the longest code
    localparam int BUF_W        = GROUP_BITS - 1 + MAX_CODE_LEN;
    localparam int CNT_W        = $clog2(BUF_W + 1);

    // Request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } hcbp_cmd_e;

    // Request item
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [CLEN_W-1:0] code_length;
    } hcbp_in_t;

    // Result item
    typedef struct packed {
        logic [GROUP_BITS-1:0] group;
        logic                  last;
    } hcbp_out_t;

    // Code table entry
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } hcbp_entry_t;

    // Classified operation handed from front to back
    typedef struct packed {
        logic              is_flush;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } hcbp_op_t;

endpackage

// ----- design/hcbp_front.sv -----
// Front end: accepts requests, holds the code table, looks up encode symbols.
// Depends on hcbp_pkg.
module hcbp_front
    import hcbp_pkg::*;
#(
    parameter int NUM_SYMBOLS = 128
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  hcbp_in_t cmd_data,
    output logic     op_valid,
    input  logic     op_ready,
    output hcbp_op_t op_data
);

    localparam int IDX_W = $clog2(NUM_SYMBOLS);

    hcbp_entry_t          code_mem [NUM_SYMBOLS];
    hcbp_entry_t          rd_entry_reg;
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 s1_flush_reg;
    logic                 s1_flush_next;

    logic                 accept;
    logic                 in_range;
    logic                 is_load;
    logic                 is_encode;
    logic                 is_flush;
    logic                 keep;
    logic                 s1_free;
    logic [IDX_W-1:0]     addr;
    logic [LEN_W-1:0]     len_clamp;
    logic [CODE_W-1:0]    code_mask;
    hcbp_entry_t          wr_entry;

    // Command decode
    always_comb
    begin
        is_load   = 1'b0;
        is_encode = 1'b0;
        is_flush  = 1'b0;
        unique case (hcbp_cmd_e'(cmd_data.command))
            CMD_LOAD:   is_load   = 1'b1;
            CMD_ENCODE: is_encode = 1'b1;
            CMD_FLUSH:  is_flush  = 1'b1;
            default:    ;
        endcase
    end

    assign accept   = cmd_valid && cmd_ready;
    assign in_range = int'(cmd_data.symbol) < NUM_SYMBOLS;
    assign addr     = IDX_W'(cmd_data.symbol);

    // Clamp overlong lengths and drop code bits above the length
    always_comb
    begin
        if (int'(cmd_data.code_length) > MAX_CODE_LEN)
            len_clamp = LEN_W'(MAX_CODE_LEN);
        else
            len_clamp = LEN_W'(cmd_data.code_length);
        if (int'(len_clamp) >= CODE_W)
            code_mask = '1;
        else
            code_mask = (CODE_W'(1) << len_clamp) - CODE_W'(1);
        wr_entry.len  = len_clamp;
        wr_entry.code = cmd_data.code_bits & code_mask;
    end

    // Code table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (accept && is_load && in_range)
            code_mem[addr] <= wr_entry;
        if (accept && is_encode && in_range)
            rd_entry_reg <= code_mem[addr];
    end

    // Lookup stage; zero-length codes are dropped here
    assign keep      = s1_flush_reg || (rd_entry_reg.len != '0);
    assign op_valid  = s1_valid_reg && keep;
    assign s1_free   = !s1_valid_reg || !keep || op_ready;
    assign cmd_ready = s1_free;

    always_comb
    begin
        op_data.is_flush = s1_flush_reg;
        op_data.len      = rd_entry_reg.len;
        op_data.code     = rd_entry_reg.code;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_flush_next = s1_flush_reg;
        if (s1_free)
        begin
            s1_valid_next = accept && (is_flush || (is_encode && in_range));
            s1_flush_next = accept && is_flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_flush_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_flush_reg <= s1_flush_next;
        end
    end

    // A table load never produces an operation for the back end
    a_load_no_op: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_load |=> !s1_valid_reg)
        else $error("load request produced a lookup entry");

endmodule

// ----- design/hcbp_queue.sv -----
// Short operation queue between front and back ends.
// Depends on hcbp_pkg.
module hcbp_queue
    import hcbp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  hcbp_op_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output hcbp_op_t pop_data
);

    localparam int QPTR_W = $clog2(DEPTH);
    localparam int QCNT_W = $clog2(DEPTH + 1);

    hcbp_op_t            entry_reg [DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                push;
    logic                pop;

    assign push_ready = count_reg != QCNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + QCNT_W'(1))
        else $error("queue occupancy did not grow on push");

endmodule

// ----- design/hcbp_back.sv -----
// Back end: bit buffer, group extraction and the output register.
// Depends on hcbp_pkg.
module hcbp_back
    import hcbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  hcbp_op_t  pop_data,
    output logic      grp_valid,
    input  logic      grp_ready,
    output hcbp_out_t grp_data
);

    logic [BUF_W-1:0]      buf_reg;
    logic [BUF_W-1:0]      buf_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    hcbp_out_t             out_reg;
    hcbp_out_t             out_next;

    logic                  can_out;
    logic                  have_group;
    logic                  pop;
    logic                  out_load;
    logic [BUF_W-1:0]      work_buf;
    logic [CNT_W-1:0]      work_cnt;
    logic [CNT_W-1:0]      rem_cnt;
    logic [BUF_W-1:0]      shifted;
    logic [GROUP_BITS-1:0] flush_grp;

    assign can_out    = !out_valid_reg || grp_ready;
    assign have_group = cnt_reg >= CNT_W'(GROUP_BITS);
    assign pop_ready  = !have_group && can_out;
    assign pop        = pop_valid && pop_ready;

    // Leftover bits left-aligned in one group
    assign flush_grp  = buf_reg[GROUP_BITS-1:0] << (CNT_W'(GROUP_BITS) - cnt_reg);

    // Append a new code, then take the oldest complete group if there is one
    always_comb
    begin
        work_buf = buf_reg;
        work_cnt = cnt_reg;
        if (pop && !pop_data.is_flush)
        begin
            work_buf = (buf_reg << pop_data.len) | BUF_W'(pop_data.code);
            work_cnt = cnt_reg + CNT_W'(pop_data.len);
        end
        rem_cnt = work_cnt - CNT_W'(GROUP_BITS);
        shifted = work_buf >> rem_cnt;
    end

    always_comb
    begin
        buf_next       = buf_reg;
        cnt_next       = cnt_reg;
        out_load       = 1'b0;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !grp_ready;
        if (pop && pop_data.is_flush)
        begin
            out_load       = 1'b1;
            out_next.group = flush_grp;
            out_next.last  = 1'b1;
            buf_next       = '0;
            cnt_next       = '0;
        end
        else if ((have_group && can_out) || pop)
        begin
            buf_next = work_buf;
            cnt_next = work_cnt;
            if (work_cnt >= CNT_W'(GROUP_BITS))
            begin
                out_load       = 1'b1;
                out_next.group = shifted[GROUP_BITS-1:0];
                out_next.last  = rem_cnt < CNT_W'(GROUP_BITS);
                cnt_next       = rem_cnt;
            end
        end
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg       <= buf_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= out_next;
    end

    assign grp_valid = out_valid_reg;
    assign grp_data  = out_reg;

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && out_next.last |=> cnt_reg < CNT_W'(GROUP_BITS))
        else $error("full group left behind after last");

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && !out_next.last |=> cnt_reg >= CNT_W'(GROUP_BITS))
        else $error("group not marked last but none remains");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop && pop_data.is_flush |=> cnt_reg == '0)
        else $error("flush did not clear the bit buffer");

endmodule

// ----- design/huffman_code_bit_packer.sv -----
// Top level of the Huffman code bit packer.
// Depends on hcbp_pkg, hcbp_front, hcbp_queue and hcbp_back.
//
// Requests arrive on cmd_valid/cmd_ready/cmd_data: load a code table entry,
// encode a symbol, or flush. Results leave on grp_valid/grp_ready/grp_data,
// one 7-bit group per transfer, earliest bit most significant, with last set
// on the final group caused by each request.
// A flush or a group-completing encode passes the lookup register, the queue
// and the output register before its first group shows. The front takes one
// request per cycle while the queue has room; the back produces one group per
// cycle while the receiver is ready. An encode completes up to three groups
// (possibly none), a flush exactly one and a load none.
// Reset clears the bit buffer, the queue and the output valid flag at once;
// the code table is not cleared, and encoding an entry never loaded is
// undefined. When the receiver stalls the result is held in the output
// register, the queue fills, and cmd_ready drops only once it is full.
module huffman_code_bit_packer
    import hcbp_pkg::*;
#(
    parameter int NUM_SYMBOLS = 128,
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  hcbp_in_t  cmd_data,
    output logic      grp_valid,
    input  logic      grp_ready,
    output hcbp_out_t grp_data
);

    logic     op_valid;
    logic     op_ready;
    hcbp_op_t op_data;
    logic     q_valid;
    logic     q_ready;
    hcbp_op_t q_data;

    // Request intake and table lookup
    hcbp_front #(
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op_data   (op_data)
    );

    // Decoupling queue
    hcbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (op_valid),
        .push_ready (op_ready),
        .push_data  (op_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    // Bit packing and result output
    hcbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_data  (q_data),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp_data  (grp_data)
    );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for huffman_code_bit_packer: directed and random requests
// are checked against a group predictor kept inside a scoreboard class.
// Depends on hcbp_pkg and the huffman_code_bit_packer RTL.
`timescale 1ns / 100ps

module tb_top;
    import hcbp_pkg::*;

    localparam int TABLE_DEPTH   = 128;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int PHASE_ITEMS   = 110;
    localparam int HOLD_CYCLES   = 300;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    // Predicts the groups produced by each request and checks them in order
    class group_predictor;
        hcbp_entry_t      code_table [TABLE_DEPTH];
        logic [BUF_W-1:0] bit_buffer;
        logic [CNT_W-1:0] pending_bits;
        hcbp_out_t        groups_due [$];
        int               errors;

        function new();
            bit_buffer   = '0;
            pending_bits = '0;
            errors       = 0;
        endfunction

        function void note_request(hcbp_in_t req);
            int          len;
            int          count;
            int          n;
            logic [31:0] acc;
            hcbp_out_t   g;
            case (hcbp_cmd_e'(req.command))
                CMD_LOAD:
                begin
                    // overlong lengths clamp; code bits above the length are dropped
                    len = (req.code_length > MAX_CODE_LEN) ? MAX_CODE_LEN : req.code_length;
                    code_table[req.symbol].len  = LEN_W'(len);
                    code_table[req.symbol].code =
                        CODE_W'(32'(req.code_bits) & ((32'd1 << len) - 32'd1));
                end
                CMD_ENCODE:
                begin
                    len = code_table[req.symbol].len;
                    if (len != 0)
                    begin
                        count = pending_bits + len;
                        acc = ((32'(bit_buffer) << len) | 32'(code_table[req.symbol].code))
                              & ((32'd1 << count) - 32'd1);
                        n = count / GROUP_BITS;
                        // every complete group, earliest bits first
                        for (int k = 0; k < n; k++)
                        begin
                            count  -= GROUP_BITS;
                            g.group = GROUP_BITS'(acc >> count);
                            g.last  = (k == n - 1);
                            groups_due.push_back(g);
                        end
                        acc &= (32'd1 << count) - 32'd1;
                        bit_buffer   = BUF_W'(acc);
                        pending_bits = CNT_W'(count);
                    end
                end
                CMD_FLUSH:
                begin
                    // leftover bits left-aligned, zero group when empty
                    g.group = GROUP_BITS'(32'(bit_buffer) << (GROUP_BITS - pending_bits));
                    g.last  = 1'b1;
                    groups_due.push_back(g);
                    bit_buffer   = '0;
                    pending_bits = '0;
                end
                default:
                begin
                end
            endcase
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_group(hcbp_out_t got);
            hcbp_out_t want;
            if (groups_due.size() == 0)
                report_mismatch($sformatf("unexpected group %h last %b", got.group, got.last));
            else
            begin
                want = groups_due.pop_front();
                if (got.group !== want.group)
                    report_mismatch($sformatf("group %h, expected %h", got.group, want.group));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
            end
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_ready;
    hcbp_in_t  cmd_data;
    logic      grp_valid;
    logic      grp_ready;
    hcbp_out_t grp_data;

    group_predictor prediction = new();

    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;
    int stall_cycles;
    bit loaded [TABLE_DEPTH];
    int loaded_list [$];

    huffman_code_bit_packer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp_data  (grp_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Request and result monitors
    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && cmd_ready)
            prediction.note_request(cmd_data);
        if (rst_n && grp_valid && grp_ready)
            prediction.check_group(grp_data);
    end

    // Watchdog: cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (grp_valid && grp_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when asked
    initial
    begin
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                grp_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            else
            begin
                grp_ready <= ($urandom_range(99) >= recv_stall_pct);
                @(posedge clk);
            end
        end
    end

    function automatic void note_loaded(int sym);
        if (!loaded[sym])
        begin
            loaded[sym] = 1'b1;
            loaded_list.push_back(sym);
        end
    endfunction

    // Offer one request, idling first at random, and wait for it to be taken
    task automatic send_request(input hcbp_in_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= item;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
    endtask

    task automatic send_cmd(logic [CMD_W-1:0] cmd, int sym, int bits, int len);
        hcbp_in_t item;
        item.command     = cmd;
        item.symbol      = SYM_W'(sym);
        item.code_bits   = CODE_W'(bits);
        item.code_length = CLEN_W'(len);
        if (cmd == CMD_LOAD)
            note_loaded(sym);
        send_request(item);
    endtask

    // Mostly encodes of loaded symbols, with loads, flushes and some noise
    function automatic hcbp_in_t make_random_request();
        hcbp_in_t r;
        int       roll;
        int       lroll;
        roll          = $urandom_range(99);
        r.symbol      = SYM_W'($urandom_range(TABLE_DEPTH - 1));
        r.code_bits   = CODE_W'($urandom);
        r.code_length = CLEN_W'($urandom_range(31));
        if (roll < 12)
        begin
            r.command = CMD_LOAD;
            lroll = $urandom_range(99);
            if (lroll < 8)
                r.code_length = '0;
            else if (lroll < 16)
                r.code_length = CLEN_W'($urandom_range(31, MAX_CODE_LEN + 1));
            else
                r.code_length = CLEN_W'($urandom_range(MAX_CODE_LEN, 1));
            note_loaded(r.symbol);
        end
        else if (roll < 17)
            r.command = CMD_FLUSH;
        else if (roll < 19)
            r.command = CMD_UNKNOWN;
        else
        begin
            r.command = CMD_ENCODE;
            r.symbol  = SYM_W'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
        end
        return r;
    endfunction

    // Sender goes quiet until every predicted group has arrived
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (prediction.groups_due.size() != 0) @(posedge clk);
    endtask

    // Main sequence
    initial
    begin
        int sender_idle [4];
        int receiver_idle [4];

        sender_idle     = '{0, 80, 0, 29};
        receiver_idle   = '{0, 0, 80, 29};
        rst_n           = 1'b0;
        cmd_valid       = 1'b0;
        cmd_data        = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        stall_cycles    = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: table extremes, odd lengths, empty flush, one to three groups
        send_cmd(CMD_LOAD, 0, 'hFFFF, MAX_CODE_LEN);
        send_cmd(CMD_LOAD, 127, 'h0000, 1);
        send_cmd(CMD_LOAD, 1, 'hABCD, 31);      // overlong length
        send_cmd(CMD_LOAD, 2, 'hFFFF, 0);       // zero-length code
        send_cmd(CMD_LOAD, 3, 'h0005, 3);
        send_cmd(CMD_LOAD, 4, 'hFFFF, GROUP_BITS);
        send_cmd(CMD_LOAD, 5, 'h5555, MAX_CODE_LEN + 1);
        send_cmd(CMD_UNKNOWN, 127, 'hFFFF, 31); // ignored
        send_cmd(CMD_FLUSH, 0, 0, 0);           // nothing pending
        send_cmd(CMD_ENCODE, 3, 0, 0);
        send_cmd(CMD_ENCODE, 2, 0, 0);
        send_cmd(CMD_ENCODE, 3, 0, 0);
        send_cmd(CMD_ENCODE, 0, 0, 0);          // six pending plus sixteen
        send_cmd(CMD_ENCODE, 127, 0, 0);
        send_cmd(CMD_FLUSH, 0, 0, 0);
        send_cmd(CMD_ENCODE, 4, 0, 0);          // exactly one group
        send_cmd(CMD_ENCODE, 1, 0, 0);
        send_cmd(CMD_ENCODE, 5, 0, 0);
        send_cmd(CMD_FLUSH, 0, 0, 0);
        send_cmd(CMD_LOAD, 3, 'h0010, 5);       // overwrite an entry
        send_cmd(CMD_ENCODE, 3, 0, 0);
        send_cmd(CMD_FLUSH, 127, 'hFFFF, 31);
        wait_drained();

        // Random phases with different idling on each side
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = sender_idle[p];
            recv_stall_pct = receiver_idle[p];
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // long receiver hold-off while requests keep coming
                if (p == 0 && i == 40)
                    hold_off_cycles = HOLD_CYCLES;
                send_request(make_random_request());
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (prediction.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
